@@ rtl/emfd_pkg.sv @@
// Shared types and constants for the metering reply frame decoder.
// No dependencies; imported by every module of the block.
package emfd_pkg;

	// Byte framing
	localparam logic [7:0] SUM_SEED    = 8'h58;
	localparam logic [7:0] HEADER_BYTE = 8'h55;
	localparam int         CNT_W       = 5;
	localparam int         NUM_FIELDS  = 5;
	localparam int         FIELD_W     = 24;

	// Shared divider: 49-bit dividend covers (2^24 << 24) and 1e6 in Q16.16
	localparam int DIVIDEND_W = 49;
	localparam int DIVISOR_W  = 32;
	localparam int STEP_W     = 6;
	localparam logic [DIVIDEND_W-1:0] FREQ_NUM = 49'd65536000000;

	// Configuration registers
	localparam int ADDR_W = 4;
	localparam logic [1:0] REG_CUR = 2'd0;
	localparam logic [1:0] REG_VOL = 2'd1;
	localparam logic [1:0] REG_POW = 2'd2;
	localparam logic [1:0] REG_ENE = 2'd3;
	localparam logic [31:0] CUR_REF_RST = 32'd64310647;
	localparam logic [31:0] VOL_REF_RST = 32'd4063578;
	localparam logic [31:0] POW_REF_RST = 32'd152576;
	localparam logic [31:0] ENE_REF_RST = 32'd845980;

	// Field slots in the store
	localparam logic [2:0] SLOT_CUR = 3'd0;
	localparam logic [2:0] SLOT_VOL = 3'd1;
	localparam logic [2:0] SLOT_POW = 3'd2;
	localparam logic [2:0] SLOT_ENE = 3'd3;
	localparam logic [2:0] SLOT_PER = 3'd4;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_CHK = 2'd1,
		ST_HDR = 2'd2
	} status_t;

	typedef logic [NUM_FIELDS-1:0][FIELD_W-1:0] field_arr_t;

	// End-of-frame event from the framer to the sequencer
	typedef struct packed {
		logic    fire;
		status_t status;
	} frame_evt_t;

	// Where a byte position lands in the field store
	typedef struct packed {
		logic       en;
		logic [2:0] slot;
		logic [1:0] lane;
	} byte_map_t;

	function automatic byte_map_t map_pos(input logic [CNT_W-1:0] pos);
		byte_map_t  m;
		logic [4:0] q;
		m = '0;
		if (pos >= 5'd1 && pos <= 5'd6) begin
			q      = pos - 5'd1;
			m.en   = 1'b1;
			m.slot = (q >= 5'd3) ? SLOT_VOL : SLOT_CUR;
			m.lane = (q >= 5'd3) ? 2'(q - 5'd3) : 2'(q);
		end else if (pos >= 5'd10 && pos <= 5'd18) begin
			q    = pos - 5'd10;
			m.en = 1'b1;
			if (q >= 5'd6) begin
				m.slot = SLOT_PER;
				m.lane = 2'(q - 5'd6);
			end else if (q >= 5'd3) begin
				m.slot = SLOT_ENE;
				m.lane = 2'(q - 5'd3);
			end else begin
				m.slot = SLOT_POW;
				m.lane = 2'(q);
			end
		end
		return m;
	endfunction

endpackage

@@ rtl/emfd_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on emfd_pkg for operand widths.
module emfd_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [emfd_pkg::DIVIDEND_W-1:0]    dividend,
	input  logic [emfd_pkg::DIVISOR_W-1:0]     divisor,
	output logic                               busy,
	output logic                               done,
	output logic [emfd_pkg::DIVIDEND_W-1:0]    quotient
);
	import emfd_pkg::*;

	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIVIDEND_W - 1);

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_W-1:0]     cnt_q;
	logic [DIVIDEND_W-1:0] dq_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  div_q;
	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  ge;

	assign trial = {rem_q, dq_q[DIVIDEND_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// zero divisor gives an all-ones quotient, which saturates downstream
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			dq_q  <= {dq_q[DIVIDEND_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = dq_q;

endmodule

@@ rtl/emfd_frame.sv @@
// Byte framer: count, running checksum, header flag and 24-bit field store.
// Depends on emfd_pkg for the byte map and event struct.
module emfd_frame #(
	parameter int FRAME_LEN = 23
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    take,
	input  logic [7:0]              rx_byte,
	input  logic                    frame_start,
	output emfd_pkg::frame_evt_t    evt,
	output emfd_pkg::field_arr_t    fields
);
	import emfd_pkg::*;

	localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(FRAME_LEN - 1);

	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       sum_q;
	logic             header_q;
	field_arr_t       field_q;

	logic [CNT_W-1:0] pos;
	logic [7:0]       sum_base;
	logic             is_last;
	byte_map_t        bmap;

	assign pos      = frame_start ? '0 : cnt_q;
	assign sum_base = frame_start ? SUM_SEED : sum_q;
	assign is_last  = pos >= LAST_POS;
	assign bmap     = map_pos(pos);

	always_comb begin
		evt.fire = take && is_last;
		if ((sum_base ^ 8'hFF) != rx_byte) evt.status = ST_CHK;
		else if (!header_q)                evt.status = ST_HDR;
		else                               evt.status = ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			sum_q    <= SUM_SEED;
			header_q <= 1'b0;
		end else if (take) begin
			if (is_last) begin
				cnt_q <= '0;
				sum_q <= SUM_SEED;
			end else begin
				cnt_q <= pos + 1'b1;
				sum_q <= sum_base + rx_byte;
				if (pos == '0) header_q <= (rx_byte == HEADER_BYTE);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int s = 0; s < NUM_FIELDS; s++) begin
			for (int l = 0; l < 3; l++) begin
				if (take && !is_last && bmap.en && bmap.slot == 3'(s) && bmap.lane == 2'(l))
					field_q[s][l*8 +: 8] <= rx_byte;
			end
		end
	end

	assign fields = field_q;

endmodule

@@ rtl/energy_meter_frame_decoder_unit.sv @@
// Metering reply frame decoder, top level. Uses emfd_pkg, emfd_frame, emfd_div.
// The last byte of a good frame starts five 49-step divisions in the shared divider, one
// after another, and the readings go to the output register once all are done; a failed
// frame skips the divider. Throughput: one byte per cycle inside a frame, then the divider
// and the output register set the pace.
// Reset (arst_n low, asynchronous) clears framing, sequencer and output valid.
module energy_meter_frame_decoder_unit #(
	parameter int FRAME_LEN = 23
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// slave-side byte stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [7:0] rx_byte
	input  logic [0:0]                     s_tuser,   // [0] frame_start
	// master-side results
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [31:0] current_val, [63:32] voltage_val, [95:64] power_val,
	// [127:96] energy_val, [159:128] frequency_val
	output logic [159:0]                   m_tdata,
	output logic [1:0]                     m_tuser,   // [1:0] status
	// configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [emfd_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);
	import emfd_pkg::*;

	// Sequencer states
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,   // taking bytes
		S_LOAD = 4'b0010,   // kick the divider with the current operand pair
		S_WAIT = 4'b0100,   // divider running
		S_DONE = 4'b1000    // result ready, waiting for the output register
	} state_t;

	state_t state_q;

	// Reference registers
	logic [31:0] cur_ref_q, vol_ref_q, pow_ref_q, ene_ref_q;

	// Framer
	logic       s_take;
	frame_evt_t evt;
	field_arr_t fields;

	// Divider
	logic                  div_start, div_busy, div_done;
	logic [DIVIDEND_W-1:0] div_dividend, div_quot;
	logic [DIVISOR_W-1:0]  div_divisor;

	// Results gathered before the output transfer
	logic [2:0]            idx_q;
	logic [4:0][31:0]      res_q;
	status_t               res_status_q;
	logic [31:0]           res_nxt;
	logic [24:0]           pow_mag;
	logic                  pow_neg;

	// Output register
	logic                  m_tvalid_q;
	logic [159:0]          m_tdata_q;
	logic [1:0]            m_tuser_q;

	//--------------------------------------------------------------------
	// Configuration port: write in the access phase, pready tied high
	//--------------------------------------------------------------------
	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_ref_q <= CUR_REF_RST;
			vol_ref_q <= VOL_REF_RST;
			pow_ref_q <= POW_REF_RST;
			ene_ref_q <= ENE_REF_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_CUR: cur_ref_q <= pwdata;
				REG_VOL: vol_ref_q <= pwdata;
				REG_POW: pow_ref_q <= pwdata;
				REG_ENE: ene_ref_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_CUR: prdata = cur_ref_q;
			REG_VOL: prdata = vol_ref_q;
			REG_POW: prdata = pow_ref_q;
			REG_ENE: prdata = ene_ref_q;
			default: prdata = '0;
		endcase
	end

	//--------------------------------------------------------------------
	// Byte framing
	//--------------------------------------------------------------------
	assign s_tready = (state_q == S_IDLE);
	assign s_take   = s_tvalid && s_tready;

	emfd_frame #(.FRAME_LEN(FRAME_LEN)) u_frame (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (s_take),
		.rx_byte     (s_tdata),
		.frame_start (s_tuser[0]),
		.evt         (evt),
		.fields      (fields)
	);

	//--------------------------------------------------------------------
	// Operand selection for the shared divider.
	// Scaled values: (raw << 24) / ref; frequency: 1e6 in Q16.16 / period.
	// Power works on the magnitude; the sign is put back in the saturation logic.
	//--------------------------------------------------------------------
	assign pow_neg = fields[SLOT_POW][FIELD_W-1];
	assign pow_mag = pow_neg ? (25'h1000000 - {1'b0, fields[SLOT_POW]})
	                         : {1'b0, fields[SLOT_POW]};

	always_comb begin
		case (idx_q)
			SLOT_CUR: begin
				div_dividend = {1'b0, fields[SLOT_CUR], 24'b0};
				div_divisor  = cur_ref_q;
			end
			SLOT_VOL: begin
				div_dividend = {1'b0, fields[SLOT_VOL], 24'b0};
				div_divisor  = vol_ref_q;
			end
			SLOT_POW: begin
				div_dividend = {pow_mag, 24'b0};
				div_divisor  = pow_ref_q;
			end
			SLOT_ENE: begin
				div_dividend = {1'b0, fields[SLOT_ENE], 24'b0};
				div_divisor  = ene_ref_q;
			end
			default: begin
				div_dividend = FREQ_NUM;
				div_divisor  = {8'b0, fields[SLOT_PER]};
			end
		endcase
	end

	assign div_start = (state_q == S_LOAD);

	emfd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Saturation of the quotient to 32 bits; a zero divisor lands here as all ones
	always_comb begin
		if (idx_q == SLOT_POW) begin
			if (pow_neg)
				res_nxt = (|div_quot[DIVIDEND_W-1:31]) ? 32'h8000_0000 : (32'd0 - div_quot[31:0]);
			else
				res_nxt = (|div_quot[DIVIDEND_W-1:31]) ? 32'h7FFF_FFFF : div_quot[31:0];
		end else begin
			res_nxt = (|div_quot[DIVIDEND_W-1:32]) ? 32'hFFFF_FFFF : div_quot[31:0];
		end
	end

	//--------------------------------------------------------------------
	// Sequencer
	//--------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= SLOT_CUR;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (evt.fire) begin
						idx_q   <= SLOT_CUR;
						state_q <= (evt.status == ST_OK) ? S_LOAD : S_DONE;
					end
				end
				S_LOAD: state_q <= S_WAIT;
				S_WAIT: begin
					if (div_done) begin
						if (idx_q == SLOT_PER) begin
							state_q <= S_DONE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_LOAD;
						end
					end
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result registers; a failed frame clears every value
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && evt.fire) begin
			res_status_q <= evt.status;
			res_q        <= '0;
		end else if (state_q == S_WAIT && div_done) begin
			res_q[idx_q] <= res_nxt;
		end
	end

	//--------------------------------------------------------------------
	// Output register: holds one result while the next frame streams in
	//--------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == S_DONE && (!m_tvalid_q || m_tready)) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= res_q;
			m_tuser_q <= res_status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

`ifndef SYNTHESIS
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_OK |-> m_tdata == '0)
		else $error("failed frame carries non-zero values");

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> !s_tready)
		else $error("byte taken while divider running");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_WAIT)
		else $error("divider finished outside the wait state");
`endif

endmodule

@@ test/energy_meter_frame_decoder_unit_tb.sv @@
// Self-checking bench for energy_meter_frame_decoder_unit: byte stream in, frame readings out.
// Needs emfd_pkg and the block's RTL. Holds its own frame decoder and compares every reading
// against it, over several divisor settings and with random gaps on both streams.
module energy_meter_frame_decoder_unit_tb;
	import emfd_pkg::*;

	localparam int FRAME_LEN    = 23;
	localparam int DRAIN_CYCLES = 300;    // extra wait once every expected reading is back
	localparam int STALL_LIMIT  = 4000;   // quiet cycles before the run is declared hung
	localparam int PHASE_BYTES  = 250;

	typedef struct {
		logic [7:0] rx_byte;
		logic       frame_start;
	} meter_byte_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] current;
		logic [31:0] voltage;
		logic [31:0] power;
		logic [31:0] energy;
		logic [31:0] freq;
	} reading_t;

	logic         clk      = 1'b0;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata  = '0;
	logic [0:0]   s_tuser  = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [159:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         psel     = 1'b0;
	logic         penable  = 1'b0;
	logic         pwrite   = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]  pwdata   = '0;
	logic [31:0]  prdata;
	logic         pready;

	energy_meter_frame_decoder_unit #(.FRAME_LEN(FRAME_LEN)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// Bench copy of the decoder state
	logic [31:0]           divisor [4] = '{CUR_REF_RST, VOL_REF_RST, POW_REF_RST, ENE_REF_RST};
	logic [4:0]            frame_pos   = '0;
	logic [7:0]            frame_sum   = SUM_SEED;
	logic                  header_seen = 1'b0;
	logic [4:0][23:0]      raw_fields  = '0;

	meter_byte_t pending_bytes[$];
	reading_t    pending_readings[$];
	meter_byte_t tx_next;
	reading_t    new_reading, want_reading;
	bit          got_reading;
	int          fault_count  = 0;
	int          quiet_cycles = 0;
	int          tx_idle_pct  = 0;
	int          rx_stall_pct = 0;
	int          bytes_queued = 0;
	bit          gen_aligned  = 1'b1;   // stimulus side: next byte lands on position 0

	// ---------------------------------------------------------------- prediction

	// (raw << 24) / divisor, Q24.8 divisor gives Q16.16, saturating
	function automatic logic [31:0] scale_mag(input logic [23:0] raw, input logic [31:0] div);
		logic [63:0] q;
		if (div == '0)
			return 32'hFFFF_FFFF;
		q = {16'd0, raw, 24'd0} / {32'd0, div};
		return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
	endfunction

	// Signed 24-bit power, clamped to the signed 32-bit range
	function automatic logic [31:0] scale_power(input logic [23:0] raw, input logic [31:0] div);
		logic [63:0] mag, q;
		mag = raw[23] ? (64'h100_0000 - 64'(raw)) : 64'(raw);
		if (div == '0)
			return raw[23] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		q = (mag << 24) / {32'd0, div};
		if (raw[23])
			return (q >= 64'h8000_0000) ? 32'h8000_0000 : -q[31:0];
		return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
	endfunction

	function automatic logic [31:0] line_freq(input logic [23:0] period);
		logic [63:0] q;
		if (period == '0)
			return 32'hFFFF_FFFF;
		q = 64'(FREQ_NUM) / 64'(period);
		return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
	endfunction

	task automatic decode_meter_byte(input logic [7:0] b, input logic start,
			output bit done, output reading_t r);
		logic [4:0] pos;
		int         slot, lane;
		done = 1'b0;
		r    = '0;
		if (start) begin
			frame_pos = '0;
			frame_sum = SUM_SEED;
		end
		pos = frame_pos;
		if (pos < FRAME_LEN - 1) begin
			if (pos == 0)
				header_seen = (b == HEADER_BYTE);
			frame_sum = frame_sum + b;
			// positions 7-9 carry nothing we keep
			if (pos >= 1 && pos <= 6) begin
				slot = (pos - 1) / 3;
				lane = (pos - 1) % 3;
				raw_fields[slot][8*lane +: 8] = b;
			end else if (pos >= 10 && pos <= 18) begin
				slot = 2 + (pos - 10) / 3;
				lane = (pos - 10) % 3;
				raw_fields[slot][8*lane +: 8] = b;
			end
			frame_pos = pos + 5'd1;
		end else begin
			done = 1'b1;
			// checksum first, so a frame bad on both counts reports a checksum error
			if ((frame_sum ^ 8'hFF) != b)
				r.status = ST_CHK;
			else if (!header_seen)
				r.status = ST_HDR;
			else begin
				r.status  = ST_OK;
				r.current = scale_mag(raw_fields[SLOT_CUR], divisor[REG_CUR]);
				r.voltage = scale_mag(raw_fields[SLOT_VOL], divisor[REG_VOL]);
				r.power   = scale_power(raw_fields[SLOT_POW], divisor[REG_POW]);
				r.energy  = scale_mag(raw_fields[SLOT_ENE], divisor[REG_ENE]);
				r.freq    = line_freq(raw_fields[SLOT_PER]);
			end
			frame_pos = '0;
			frame_sum = SUM_SEED;
		end
	endtask

	task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			if (fault_count < 10)
				$display("%s: expected %h, got %h", what, want, got);
			fault_count++;
		end
	endtask

	// ---------------------------------------------------------------- stream sides

	// Byte driver: offers the next queued byte once the previous transfer has gone
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (pending_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				tx_next = pending_bytes.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= tx_next.rx_byte;
				s_tuser  <= tx_next.frame_start;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Monitor: predicts on each byte transfer, checks each reading transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				decode_meter_byte(s_tdata, s_tuser[0], got_reading, new_reading);
				if (got_reading)
					pending_readings.push_back(new_reading);
			end
			if (m_tvalid && m_tready) begin
				if (pending_readings.size() == 0) begin
					if (fault_count < 10)
						$display("reading with none expected: status %0d", m_tuser);
					fault_count++;
				end else begin
					want_reading = pending_readings.pop_front();
					check_field("status", 32'(want_reading.status), 32'(m_tuser));
					check_field("current_val", want_reading.current, m_tdata[31:0]);
					check_field("voltage_val", want_reading.voltage, m_tdata[63:32]);
					check_field("power_val", want_reading.power, m_tdata[95:64]);
					check_field("energy_val", want_reading.energy, m_tdata[127:96]);
					check_field("frequency_val", want_reading.freq, m_tdata[159:128]);
				end
			end
		end
	end

	// Watchdog on cycles with no transfer anywhere
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("energy_meter_frame_decoder_unit regression: fail");
			$finish;
		end
	end

	// ---------------------------------------------------------------- stimulus

	task automatic queue_byte(input logic [7:0] b, input logic start);
		meter_byte_t it;
		it.rx_byte     = b;
		it.frame_start = start;
		pending_bytes.push_back(it);
		bytes_queued++;
	endtask

	// Mostly random, with a fair share of the boundary values
	function automatic logic [23:0] pick_raw();
		case ($urandom_range(11))
			0:       return 24'h000000;
			1:       return 24'hFFFFFF;
			2:       return 24'h800000;
			3:       return 24'h7FFFFF;
			4:       return 24'h000001;
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [4:0][23:0] pick_fields();
		logic [4:0][23:0] f;
		for (int i = 0; i < 5; i++)
			f[i] = pick_raw();
		return f;
	endfunction

	task automatic queue_frame(input logic [4:0][23:0] f, input logic lead_start,
			input bit bad_hdr, input bit bad_sum);
		logic [7:0] fb [FRAME_LEN];
		logic [7:0] sum;
		int         pos;
		for (int i = 0; i < FRAME_LEN; i++)
			fb[i] = 8'($urandom);
		fb[0] = HEADER_BYTE;
		if (bad_hdr && fb[0] == HEADER_BYTE)
			fb[0] = 8'($urandom_range(255));
		if (bad_hdr && fb[0] == HEADER_BYTE)
			fb[0] = ~HEADER_BYTE;
		for (int s = 0; s < 5; s++) begin
			for (int l = 0; l < 3; l++) begin
				pos = (s < 2) ? 1 + 3*s + l : 10 + 3*(s - 2) + l;
				fb[pos] = f[s][8*l +: 8];
			end
		end
		sum = SUM_SEED;
		for (int i = 0; i < FRAME_LEN - 1; i++)
			sum = sum + fb[i];
		fb[FRAME_LEN-1] = ~sum;
		if (bad_sum)
			fb[FRAME_LEN-1] = fb[FRAME_LEN-1] ^ 8'($urandom_range(1, 255));
		for (int i = 0; i < FRAME_LEN; i++)
			queue_byte(fb[i], (i == 0) ? lead_start : 1'b0);
		gen_aligned = 1'b1;
	endtask

	// A frame cut short and then restarted with frame_start
	task automatic queue_restart(input int cut_len);
		for (int i = 0; i < cut_len; i++)
			queue_byte(8'($urandom), i == 0);
		queue_frame(pick_fields(), 1'b1, 1'b0, 1'b0);
	endtask

	task automatic random_traffic(input int n_bytes);
		int target, pick, k;
		target = bytes_queued + n_bytes;
		while (bytes_queued < target) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				// well-formed; may run straight on from the previous frame
				queue_frame(pick_fields(), gen_aligned ? 1'($urandom) : 1'b1, 1'b0, 1'b0);
			end else if (pick < 80) begin
				k = $urandom_range(1, 3);
				queue_frame(pick_fields(), 1'b1, k[0], k[1]);
			end else if (pick < 90) begin
				queue_restart($urandom_range(1, FRAME_LEN - 1));
			end else begin
				k = $urandom_range(1, 8);
				for (int i = 0; i < k; i++)
					queue_byte(8'($urandom), $urandom_range(7) == 0);
				gen_aligned = 1'b0;
			end
		end
	endtask

	task automatic set_idle(input int mode);
		case (mode)
			0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
			1:       begin tx_idle_pct = 47; rx_stall_pct = 0;  end
			2:       begin tx_idle_pct = 0;  rx_stall_pct = 47; end
			default: begin tx_idle_pct = 24; rx_stall_pct = 24; end
		endcase
	endtask

	// Hold the sender until every byte has gone and every reading has come back
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_bytes.size() != 0 || s_tvalid || pending_readings.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		divisor[idx] = value;
	endtask

	task automatic set_divisors(input logic [31:0] cur, vol, pow, ene);
		cfg_write(REG_CUR, cur);
		cfg_write(REG_VOL, vol);
		cfg_write(REG_POW, pow);
		cfg_write(REG_ENE, ene);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames at reset divisors
		set_idle(0);
		queue_frame({5{24'hFFFFFF}}, 1'b0, 1'b0, 1'b0);    // first frame straight after reset
		queue_frame('0, 1'b0, 1'b0, 1'b0);                 // runs on, zero period
		queue_frame({24'h000001, 24'h000000, 24'h800000, 24'h7FFFFF, 24'h000000},
			1'b1, 1'b0, 1'b0);
		queue_frame({24'h00FFFF, 24'h123456, 24'h7FFFFF, 24'hFFFFFF, 24'h000001},
			1'b1, 1'b0, 1'b0);
		queue_frame(pick_fields(), 1'b1, 1'b0, 1'b1);      // checksum wrong
		queue_frame(pick_fields(), 1'b1, 1'b1, 1'b0);      // header wrong
		queue_frame(pick_fields(), 1'b1, 1'b1, 1'b1);      // both wrong
		queue_restart(10);
		wait_drained();
		random_traffic(PHASE_BYTES);
		wait_drained();

		// Divisor sweeps, extremes included, each with its own idle pattern
		set_idle(1);
		set_divisors(32'd1, 32'd1, 32'd1, 32'd1);
		random_traffic(PHASE_BYTES);
		wait_drained();

		set_idle(2);
		set_divisors('1, '1, '1, '1);
		random_traffic(PHASE_BYTES);
		wait_drained();

		set_idle(3);
		set_divisors($urandom, $urandom_range(1, 65535), $urandom_range(1, 1 << 20), $urandom);
		random_traffic(PHASE_BYTES);
		wait_drained();

		set_idle(0);
		set_divisors(CUR_REF_RST, VOL_REF_RST, POW_REF_RST, ENE_REF_RST);
		random_traffic(PHASE_BYTES);
		wait_drained();

		// zero divisors must saturate
		set_idle(1);
		set_divisors('0, '0, '0, '0);
		random_traffic(PHASE_BYTES);
		wait_drained();

		set_idle(3);
		set_divisors($urandom_range(1, 255), $urandom, $urandom, $urandom_range(1, 4096));
		random_traffic(PHASE_BYTES);
		wait_drained();

		if (fault_count == 0 && pending_readings.size() == 0)
			$display("energy_meter_frame_decoder_unit regression: pass");
		else
			$display("energy_meter_frame_decoder_unit regression: fail");
		$finish;
	end

endmodule
